// File: rtl/juu_pkg.sv
package juu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_end;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        done_res;
		logic [1:0]  status;
		logic        last_in_run;
	} out_item_t;

	// Results of one byte: up to two, held in order, with their count.
	typedef struct packed {
		out_item_t  res0;
		out_item_t  res1;
		logic [1:0] cnt;
	} dec_t;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_CONT   = 2'd1;
	localparam logic [1:0] ST_UNFINISHED = 2'd2;

	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_N         = 8'h6e;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;

	localparam logic [15:0] HI_SURR   = 16'hd800;
	localparam logic [15:0] LO_SURR   = 16'hdc00;
	localparam logic [20:0] BMP_MAX   = 21'h00ffff;
	localparam logic [20:0] SUPP_BASE = 21'h010000;

	function automatic logic [7:0] escape_map(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			CH_B:    r = 8'h08;
			CH_F:    r = 8'h0c;
			CH_N:    r = 8'h0a;
			CH_R:    r = 8'h0d;
			CH_T:    r = 8'h09;
			default: r = b;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/juu_stream_if.sv
interface juu_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/juu_dec.sv
module juu_dec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  juu_pkg::in_item_t item,
	output juu_pkg::dec_t     dec
);

	logic        escape_q;
	logic [1:0]  remain_q;
	logic [20:0] accum_q;
	logic [1:0]  err_q;

	logic        n_esc;
	logic [1:0]  n_rem;
	logic [20:0] n_acc;
	logic [1:0]  n_err;
	logic [20:0] acc_new;
	logic [20:0] supp;
	logic [15:0] u0;
	logic [15:0] u1;
	logic [1:0]  nu;
	logic [1:0]  st;
	logic [7:0]  b;
	juu_pkg::out_item_t bare;

	always_comb begin
		b       = item.in_byte;
		n_esc   = escape_q;
		n_rem   = remain_q;
		n_acc   = accum_q;
		n_err   = err_q;
		u0      = '0;
		u1      = '0;
		nu      = 2'd0;
		acc_new = {accum_q[14:0], b[5:0]};
		supp    = acc_new - juu_pkg::SUPP_BASE;
		if (err_q == juu_pkg::ST_OK) begin
			if (escape_q) begin
				u0    = {8'h00, juu_pkg::escape_map(b)};
				nu    = 2'd1;
				n_esc = 1'b0;
			end else if (remain_q != 2'd0) begin
				if (b[7:6] == 2'b10) begin
					n_acc = acc_new;
					n_rem = remain_q - 2'd1;
					if (remain_q == 2'd1) begin
						if (acc_new > juu_pkg::BMP_MAX) begin
							u0 = juu_pkg::HI_SURR | {6'd0, supp[19:10]};
							u1 = juu_pkg::LO_SURR | {6'd0, supp[9:0]};
							nu = 2'd2;
						end else begin
							u0 = acc_new[15:0];
							nu = 2'd1;
						end
					end
				end else begin
					n_err = juu_pkg::ST_BAD_CONT;
					n_rem = 2'd0;
				end
			end else if (!b[7]) begin
				if (b == juu_pkg::CH_BACKSLASH) begin
					n_esc = 1'b1;
				end else begin
					u0 = {8'h00, b};
					nu = 2'd1;
				end
			end else if (b[7:5] == 3'b110) begin
				n_acc = {16'd0, b[4:0]};
				n_rem = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				n_acc = {17'd0, b[3:0]};
				n_rem = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				n_acc = {18'd0, b[2:0]};
				n_rem = 2'd3;
			end
		end

		st = n_err;
		if (st == juu_pkg::ST_OK && (n_esc || n_rem != 2'd0)) begin
			st = juu_pkg::ST_UNFINISHED;
		end
		bare = '{code_unit: 16'd0, unit_valid: 1'b0, done_res: 1'b1, status: st,
			last_in_run: 1'b1};

		dec.res0 = '{code_unit: u0, unit_valid: 1'b1, done_res: 1'b0,
			status: juu_pkg::ST_OK, last_in_run: (nu == 2'd1)};
		dec.res1 = '{code_unit: u1, unit_valid: 1'b1, done_res: 1'b0,
			status: juu_pkg::ST_OK, last_in_run: 1'b1};
		dec.cnt  = nu;
		if (item.string_end) begin
			if (st == juu_pkg::ST_OK && nu != 2'd0) begin
				dec.res0.done_res = (nu == 2'd1);
				dec.res1.done_res = 1'b1;
			end else if (nu == 2'd0) begin
				dec.res0 = bare;
				dec.cnt  = 2'd1;
			end else begin
				dec.res0.last_in_run = 1'b0;
				dec.res1 = bare;
				dec.cnt  = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			remain_q <= 2'd0;
			accum_q  <= '0;
			err_q    <= juu_pkg::ST_OK;
		end else if (step) begin
			if (item.string_end) begin
				escape_q <= 1'b0;
				remain_q <= 2'd0;
				accum_q  <= '0;
				err_q    <= juu_pkg::ST_OK;
			end else begin
				escape_q <= n_esc;
				remain_q <= n_rem;
				accum_q  <= n_acc;
				err_q    <= n_err;
			end
		end
	end

endmodule

// File: rtl/juu_outbuf.sv
module juu_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  juu_pkg::dec_t        dec,
	output logic                 free,
	juu_stream_if.source         units
);

	logic               vld_q;
	logic               two_q;
	logic               idx_q;
	juu_pkg::out_item_t res0_q;
	juu_pkg::out_item_t res1_q;
	logic               pop;

	assign pop         = vld_q && units.ready;
	assign free        = !vld_q || (units.ready && (idx_q == two_q));
	assign units.valid = vld_q;
	assign units.data  = idx_q ? res1_q : res0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			two_q <= 1'b0;
			idx_q <= 1'b0;
		end else if (push) begin
			vld_q <= 1'b1;
			two_q <= (dec.cnt == 2'd2);
			idx_q <= 1'b0;
		end else if (pop) begin
			if (idx_q == two_q) begin
				vld_q <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res0_q <= dec.res0;
			res1_q <= dec.res1;
		end
	end

	// A status other than ok only comes on a bare final result.
	a_status_bare: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && units.data.status != juu_pkg::ST_OK |->
			units.data.done_res && !units.data.unit_valid)
		else $error("error status on a result that is not a bare final one");

	// The final result of a string always closes the run of its byte.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && units.data.done_res |-> units.data.last_in_run)
		else $error("final result not marked last in run");

	// The second result of a byte follows once the first one is taken.
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !units.data.last_in_run |=> vld_q && idx_q)
		else $error("second result of a byte went missing");

	// Only the second slot of a pair is ever shown after the first.
	a_idx_pair: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && idx_q |-> two_q)
		else $error("second slot shown for a single result");

endmodule

// File: rtl/json_utf8_unescape_to_utf16_top.sv
// Decodes the body of a JSON string, one byte per item on bytes, into UTF-16
// code units on units. A byte is taken in every cycle as long as the results
// are taken; each byte passes an input register and the decoder into the result
// buffer, which offers its first result. A byte that completes a code point above
// 0xFFFF, or that ends a string with a unit while leaving a status to report, yields
// two results, and the single result buffer then holds the byte stream until the
// second result is taken. Each string closes with a result that has done_res set;
// a status other than ok is always reported on a bare result with unit_valid low.
module json_utf8_unescape_to_utf16_top (
	input logic          clk,
	input logic          arst_n,
	juu_stream_if.sink   bytes,
	juu_stream_if.source units
);

	logic              s1_valid;
	juu_pkg::in_item_t item_s1;
	logic              free;
	logic              adv;
	juu_pkg::dec_t     dec;

	assign adv         = s1_valid && free;
	assign bytes.ready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (bytes.ready) begin
			s1_valid <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			item_s1 <= bytes.data;
		end
	end

	juu_dec u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.dec    (dec)
	);

	juu_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv && dec.cnt != 2'd0),
		.dec    (dec),
		.free   (free),
		.units  (units)
	);

endmodule
